@@ sv/quadratic_root_solver_defines.svh @@
// quadratic_root_solver_defines.svh: assertion macros for the checker.
// Depends on nothing.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH
// implication checked every clock outside reset
`define QRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ sv/qrs_pkg.sv @@
// qrs_pkg: constants, types and codes of the quadratic root solver.
// Used by quadratic_root_solver and qrs_checker.
package qrs_pkg;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int KIND_WIDTH     = 2;
   localparam logic [KIND_WIDTH-1:0] KIND_REAL    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_COMPLEX = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ZERO_A  = 2'd2;

   // status carried alongside the datapath
   typedef struct packed {
      logic zero_a;
      logic real_pair;
      logic neg_den;
   } flags_type;
endpackage

@@ sv/qrs_stream_if.sv @@
// qrs_stream_if: valid/ready channel carrying one word of payload.
// Depends on nothing.
interface qrs_stream_if #(
   parameter int W = 8
);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ sv/qrs_sqrt_stage.sv @@
// qrs_sqrt_stage: STEPS result bits of a restoring square root, registered.
// Part of the quadratic root solver pipeline; no package use.
module qrs_sqrt_stage #(
   parameter int RW    = 34,
   parameter int STEPS = 4,
   parameter int PW    = 70
) (
   input  logic          clock,
   input  logic          en,
   input  logic [PW-1:0] rad_in,
   input  logic [RW-1:0] root_in,
   input  logic [RW+1:0] rem_in,
   output logic [PW-1:0] rad_ff,
   output logic [RW-1:0] root_ff,
   output logic [RW+1:0] rem_ff
);
   logic [PW-1:0] rad_c;
   logic [RW-1:0] root_c;
   logic [RW+1:0] rem_c;
   logic [RW+1:0] trial;

   always_comb begin
      rad_c  = rad_in;
      root_c = root_in;
      rem_c  = rem_in;
      for (int i = 0; i < STEPS; i++) begin
         rem_c  = {rem_c[RW-1:0], rad_c[PW-1:PW-2]};
         rad_c  = {rad_c[PW-3:0], 2'b00};
         trial  = {root_c, 2'b01};
         if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[RW-2:0], 1'b1};
         end else begin
            root_c = {root_c[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_c;
         root_ff <= root_c;
         rem_ff  <= rem_c;
      end
   end
endmodule

@@ sv/qrs_div_stage.sv @@
// qrs_div_stage: STEPS quotient bits of a restoring unsigned divide, registered.
// Part of the quadratic root solver pipeline; no package use.
module qrs_div_stage #(
   parameter int NW    = 40,
   parameter int DW    = 18,
   parameter int STEPS = 4
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] den,
   input  logic [NW-1:0] num_in,
   input  logic [DW:0]   rem_in,
   output logic [NW-1:0] num_ff,
   output logic [DW:0]   rem_ff
);
   logic [NW-1:0] num_c;
   logic [DW:0]   rem_c;
   logic [DW+1:0] sh;

   // num shifts out numerator bits on top and collects quotient bits below
   always_comb begin
      num_c = num_in;
      rem_c = rem_in;
      for (int i = 0; i < STEPS; i++) begin
         sh    = {rem_c, num_c[NW-1]};
         num_c = {num_c[NW-2:0], 1'b0};
         if (sh >= {2'b00, den}) begin
            sh       = sh - {2'b00, den};
            num_c[0] = 1'b1;
         end
         rem_c = sh[DW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_c;
         rem_ff <= rem_c;
      end
   end
endmodule

@@ sv/quadratic_root_solver.sv @@
// Quadratic root solver: roots of a*x^2+b*x+c in signed Q.FRAC_BITS fixed point.
// Throughput one word per clock while the output is not stalled; the root and
// two dividers are unrolled stages. Stalls freeze the whole pipe.
// Synchronous reset clears the valid bits only.
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   qrs_stream_if.sink   req,
   qrs_stream_if.source rsp
);
   localparam int OW  = COEF_WIDTH + FRAC_BITS + 3;
   localparam int DWD = 2*COEF_WIDTH + 3;          // signed discriminant width
   localparam int RW  = COEF_WIDTH + 1 + FRAC_BITS; // root bits
   localparam int SQ_STEPS = 4;
   localparam int SQ_N = (RW + SQ_STEPS - 1) / SQ_STEPS;
   localparam int SQ_T = SQ_N * SQ_STEPS;
   localparam int PW  = 2*SQ_T;                     // radicand bits
   localparam int DEN_W = COEF_WIDTH + 1;
   localparam int NW  = COEF_WIDTH + FRAC_BITS + 2; // |numerator| bits
   localparam int DV_STEPS = 4;
   localparam int DV_N = (NW + DV_STEPS - 1) / DV_STEPS;
   localparam int DV_T = DV_N * DV_STEPS;
   localparam int DEPTH = 3 + SQ_N + DV_N + 1;

   logic adv;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   assign adv = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = adv;

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req.valid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: capture and products
   logic signed [COEF_WIDTH-1:0] a_in, b_in, c_in;
   assign a_in = req.data[3*COEF_WIDTH-1:2*COEF_WIDTH];
   assign b_in = req.data[2*COEF_WIDTH-1:COEF_WIDTH];
   assign c_in = req.data[COEF_WIDTH-1:0];
   logic signed [2*COEF_WIDTH-1:0] bb_ff, ac_ff;
   logic signed [COEF_WIDTH-1:0]   a1_ff, b1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff <= b_in * b_in;
         ac_ff <= a_in * c_in;
         a1_ff <= a_in;
         b1_ff <= b_in;
      end
   end

   // stage 2: discriminant
   logic signed [DWD-1:0] d_ff;
   logic signed [COEF_WIDTH-1:0] a2_ff, b2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff  <= DWD'(bb_ff) - (DWD'(ac_ff) <<< 2);
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   // stage 3: magnitude and flags
   logic [DWD-1:0] dabs;
   assign dabs = d_ff[DWD-1] ? DWD'(-d_ff) : DWD'(d_ff);
   logic [PW-1:0] rad3_ff;
   qrs_pkg::flags_type fl3_ff;
   logic signed [COEF_WIDTH-1:0] a3_ff, b3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rad3_ff          <= PW'(dabs) << (2*FRAC_BITS);
         fl3_ff.zero_a    <= (a2_ff == '0);
         fl3_ff.real_pair <= !d_ff[DWD-1] && (d_ff != '0);
         fl3_ff.neg_den   <= a2_ff[COEF_WIDTH-1];
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
      end
   end

   // square root stages; extra leading pairs are zero when SQ_T > RW
   logic [PW-1:0]   sq_rad [SQ_N+1];
   logic [SQ_T-1:0] sq_root[SQ_N+1];
   logic [SQ_T+1:0] sq_rem [SQ_N+1];
   qrs_pkg::flags_type fl_p [SQ_N+1];
   logic signed [COEF_WIDTH-1:0] a_p [SQ_N+1];
   logic signed [COEF_WIDTH-1:0] b_p [SQ_N+1];
   assign sq_rad[0]  = rad3_ff;
   assign sq_root[0] = '0;
   assign sq_rem[0]  = '0;
   assign fl_p[0] = fl3_ff;
   assign a_p[0]  = a3_ff;
   assign b_p[0]  = b3_ff;
   for (genvar g = 0; g < SQ_N; g++) begin : g_sq
      qrs_sqrt_stage #(.RW(SQ_T), .STEPS(SQ_STEPS), .PW(PW)) u_sq (
         .clock, .en(adv),
         .rad_in(sq_rad[g]), .root_in(sq_root[g]), .rem_in(sq_rem[g]),
         .rad_ff(sq_rad[g+1]), .root_ff(sq_root[g+1]), .rem_ff(sq_rem[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            fl_p[g+1] <= fl_p[g];
            a_p[g+1]  <= a_p[g];
            b_p[g+1]  <= b_p[g];
         end
      end
   end

   // numerators and sign handling
   logic [RW-1:0] s;
   assign s = sq_root[SQ_N][RW-1:0];
   logic signed [NW:0] nb, n1, n2;
   assign nb = -((NW+1)'(b_p[SQ_N]) <<< FRAC_BITS);
   qrs_pkg::flags_type flx;
   assign flx = fl_p[SQ_N];
   always_comb begin
      if (flx.real_pair) begin
         n1 = nb + (NW+1)'(s);
         n2 = nb - (NW+1)'(s);
      end else begin
         n1 = nb;
         n2 = (NW+1)'(s);
      end
   end
   logic [DEN_W-1:0] den_abs;
   logic signed [DEN_W-1:0] den_s;
   assign den_s   = {a_p[SQ_N], 1'b0};
   assign den_abs = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
   logic [NW-1:0] m1, m2;
   assign m1 = n1[NW] ? NW'(-n1) : NW'(n1);
   assign m2 = n2[NW] ? NW'(-n2) : NW'(n2);
   logic neg1, neg2;
   assign neg1 = n1[NW] ^ flx.neg_den;
   assign neg2 = n2[NW] ^ flx.neg_den;

   // numerators enter with leading zero bits when DV_T > NW
   logic [DV_T-1:0] q1 [DV_N+1];
   logic [DV_T-1:0] q2 [DV_N+1];
   logic [DEN_W:0]  r1 [DV_N+1];
   logic [DEN_W:0]  r2 [DV_N+1];
   logic [DEN_W-1:0] den_p [DV_N+1];
   logic [1:0] ng_p [DV_N+1];
   logic [qrs_pkg::KIND_WIDTH-1:0] kd_p [DV_N+1];
   assign q1[0] = DV_T'(m1);
   assign q2[0] = DV_T'(m2);
   assign r1[0] = '0;
   assign r2[0] = '0;
   assign den_p[0] = den_abs;
   assign ng_p[0]  = {neg1, neg2};
   assign kd_p[0]  = flx.zero_a ? qrs_pkg::KIND_ZERO_A :
                     (flx.real_pair ? qrs_pkg::KIND_REAL : qrs_pkg::KIND_COMPLEX);
   for (genvar g = 0; g < DV_N; g++) begin : g_dv
      qrs_div_stage #(.NW(DV_T), .DW(DEN_W), .STEPS(DV_STEPS)) u_d1 (
         .clock, .en(adv), .den(den_p[g]),
         .num_in(q1[g]), .rem_in(r1[g]), .num_ff(q1[g+1]), .rem_ff(r1[g+1])
      );
      qrs_div_stage #(.NW(DV_T), .DW(DEN_W), .STEPS(DV_STEPS)) u_d2 (
         .clock, .en(adv), .den(den_p[g]),
         .num_in(q2[g]), .rem_in(r2[g]), .num_ff(q2[g+1]), .rem_ff(r2[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            den_p[g+1] <= den_p[g];
            ng_p[g+1]  <= ng_p[g];
            kd_p[g+1]  <= kd_p[g];
         end
      end
   end

   // output register: sign restore, roots cleared for zero a
   logic [OW-1:0] o1, o2;
   logic [qrs_pkg::KIND_WIDTH-1:0] ok;
   logic [OW-1:0] qa, qb;
   assign qa = OW'(q1[DV_N][NW-1:0]);
   assign qb = OW'(q2[DV_N][NW-1:0]);
   logic [OW-1:0] o1_ff, o2_ff;
   logic [qrs_pkg::KIND_WIDTH-1:0] ok_ff;
   always_comb begin
      ok = kd_p[DV_N];
      o1 = ng_p[DV_N][1] ? OW'(-qa) : qa;
      o2 = ng_p[DV_N][0] ? OW'(-qb) : qb;
      if (ok == qrs_pkg::KIND_ZERO_A) begin
         o1 = '0;
         o2 = '0;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff <= o1;
         o2_ff <= o2;
         ok_ff <= ok;
      end
   end
   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.data  = {ok_ff, o1_ff, o2_ff};
endmodule

@@ sv/qrs_checker.sv @@
// qrs_checker: port-level assertions for quadratic_root_solver, bound below.
// Depends on quadratic_root_solver_defines.svh and qrs_pkg.
`include "quadratic_root_solver_defines.svh"
module qrs_checker #(
   parameter int OW = 35
) (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [OW*2+1:0] rsp_data
);
   `QRS_ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid, "valid after reset")
   `QRS_ASSERT_IMPL(a_kind, clock, reset, rsp_valid, rsp_data[OW*2+1:OW*2] <= qrs_pkg::KIND_ZERO_A, "bad root kind")
   `QRS_ASSERT_IMPL(a_zero, clock, reset, rsp_valid && rsp_data[OW*2+1:OW*2] == qrs_pkg::KIND_ZERO_A, rsp_data[OW*2-1:0] == '0, "zero a gives nonzero values")
   `QRS_ASSERT_IMPL(a_flow, clock, reset, !rsp_valid || rsp_ready, req_ready, "input blocked while output drains")
endmodule

bind quadratic_root_solver qrs_checker #(.OW(COEF_WIDTH + FRAC_BITS + 3)) u_qrs_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
